// ===== sv/dle_pkg.sv =====
// Shared constants, types and state codes of the DNS label encoder.
package dle_pkg;

  localparam int unsigned MaxLabel = 63;
  localparam int unsigned CntW     = $clog2(MaxLabel + 1);
  localparam int unsigned AddrW    = $clog2(MaxLabel);
  localparam int unsigned ByteW    = 8;

  localparam logic [ByteW-1:0] DotChar = 8'h2E;

  localparam logic FuncChar = 1'b0;
  localparam logic FuncEnd  = 1'b1;

  typedef enum logic [1:0] {
    StIdle,
    StLen,
    StData,
    StZero
  } state_e;

  typedef struct packed {
    logic             vld;
    logic [ByteW-1:0] out_byte;
    logic             run_last;
    logic             label_truncated;
  } out_word_t;

  typedef struct packed {
    logic             we;
    logic [AddrW-1:0] waddr;
    logic [ByteW-1:0] wdata;
    logic             re;
    logic [AddrW-1:0] raddr;
  } ram_req_t;

endpackage

// ===== sv/dle_ram.sv =====
// Simple dual-port synchronous RAM with a registered read port.
module dle_ram #(
  parameter int unsigned Depth = 63,
  parameter int unsigned Width = 8,
  parameter int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/dle_ctrl.sv =====
// Label buffering and replay sequencer of the DNS label encoder.
module dle_ctrl (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic                      in_func_i,
  input  logic [dle_pkg::ByteW-1:0] in_char_i,
  input  logic                      out_free_i,
  output dle_pkg::out_word_t        out_word_o,
  output dle_pkg::ram_req_t         ram_req_o,
  input  logic [dle_pkg::ByteW-1:0] ram_rdata_i
);

  dle_pkg::state_e state_q, state_d;

  logic [dle_pkg::CntW-1:0]  cnt_q, cnt_d;
  logic                      ovf_q, ovf_d;
  logic                      pend_q, pend_d;
  logic [dle_pkg::CntW-1:0]  len_q, len_d;
  logic                      trunc_q, trunc_d;
  logic [dle_pkg::AddrW-1:0] idx_q, idx_d;
  logic                      in_acc;
  logic                      is_dot;
  logic                      data_last;

  assign in_ready_o = (state_q == dle_pkg::StIdle);
  assign in_acc     = in_valid_i && in_ready_o;
  assign is_dot     = (in_char_i == dle_pkg::DotChar);
  assign data_last  = (dle_pkg::CntW'(idx_q) + dle_pkg::CntW'(1)) == len_q;

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      dle_pkg::StIdle: begin
        if (in_acc) begin
          if (in_func_i == dle_pkg::FuncEnd) begin
            state_d = dle_pkg::StZero;
          end else if (is_dot) begin
            state_d = dle_pkg::StLen;
          end
        end
      end
      dle_pkg::StLen: begin
        if (out_free_i) begin
          state_d = (len_q == '0) ? dle_pkg::StIdle : dle_pkg::StData;
        end
      end
      dle_pkg::StData: begin
        if (pend_q && out_free_i && data_last) begin
          state_d = dle_pkg::StIdle;
        end
      end
      dle_pkg::StZero: begin
        if (out_free_i) begin
          state_d = dle_pkg::StIdle;
        end
      end
      default: state_d = dle_pkg::StIdle;
    endcase
  end

  // Datapath and outputs.
  always_comb begin
    cnt_d      = cnt_q;
    ovf_d      = ovf_q;
    pend_d     = pend_q;
    len_d      = len_q;
    trunc_d    = trunc_q;
    idx_d      = idx_q;
    out_word_o = '0;
    ram_req_o  = '0;
    unique case (state_q)
      dle_pkg::StIdle: begin
        if (in_acc) begin
          if (in_func_i == dle_pkg::FuncEnd) begin
            cnt_d = '0;
            ovf_d = 1'b0;
          end else if (!is_dot) begin
            if (cnt_q < dle_pkg::CntW'(dle_pkg::MaxLabel)) begin
              ram_req_o.we    = 1'b1;
              ram_req_o.waddr = cnt_q[dle_pkg::AddrW-1:0];
              ram_req_o.wdata = in_char_i;
              cnt_d           = cnt_q + dle_pkg::CntW'(1);
            end else begin
              ovf_d = 1'b1;
            end
          end else begin
            len_d   = cnt_q;
            trunc_d = ovf_q;
            cnt_d   = '0;
            ovf_d   = 1'b0;
          end
        end
      end
      dle_pkg::StLen: begin
        if (out_free_i) begin
          out_word_o.vld             = 1'b1;
          out_word_o.out_byte        = dle_pkg::ByteW'(len_q);
          out_word_o.run_last        = (len_q == '0);
          out_word_o.label_truncated = trunc_q;
          if (len_q != '0) begin
            // Fetch the first character; it shows up on the read port next cycle.
            ram_req_o.re    = 1'b1;
            ram_req_o.raddr = '0;
            idx_d           = '0;
            pend_d          = 1'b1;
          end
        end
      end
      dle_pkg::StData: begin
        // The read register holds its word while the output is stalled.
        if (pend_q && out_free_i) begin
          out_word_o.vld             = 1'b1;
          out_word_o.out_byte        = ram_rdata_i;
          out_word_o.run_last        = data_last;
          out_word_o.label_truncated = trunc_q;
          if (data_last) begin
            pend_d = 1'b0;
          end else begin
            ram_req_o.re    = 1'b1;
            ram_req_o.raddr = idx_q + dle_pkg::AddrW'(1);
            idx_d           = idx_q + dle_pkg::AddrW'(1);
          end
        end
      end
      dle_pkg::StZero: begin
        if (out_free_i) begin
          out_word_o.vld      = 1'b1;
          out_word_o.run_last = 1'b1;
        end
      end
      default: begin
        pend_d = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= dle_pkg::StIdle;
      cnt_q   <= '0;
      ovf_q   <= 1'b0;
      pend_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      ovf_q   <= ovf_d;
      pend_q  <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    len_q   <= len_d;
    trunc_q <= trunc_d;
    idx_q   <= idx_d;
  end

`ifndef SYNTHESIS
  a_write_only_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_req_o.we |-> state_q == dle_pkg::StIdle)
    else $error("label store written outside idle");

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= dle_pkg::CntW'(dle_pkg::MaxLabel))
    else $error("label count beyond capacity");

  a_data_needs_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_word_o.vld && state_q == dle_pkg::StData) |-> pend_q)
    else $error("label byte sent without a pending read");

  a_dot_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && in_func_i == dle_pkg::FuncChar && is_dot) |=> (cnt_q == '0 && !ovf_q))
    else $error("label not cleared after dot");

  a_idx_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == dle_pkg::StData && pend_q) |-> dle_pkg::CntW'(idx_q) < len_q)
    else $error("replay index beyond label length");
`endif

endmodule

// ===== sv/dns_label_encoder.sv =====
// Top level of the DNS label encoder: sequencer, label store and output register.
//
//   channel   | direction | tdata            | tuser           | tlast
//   s_axis    | in        | name_char [7:0]  | func            | -
//   m_axis    | out       | out_byte [7:0]   | label_truncated | run_last
//
// A name character is written to the label store unless 63 are already held.
// A dot is followed by the length byte and then the label characters; the store is
// read one address per cycle while m_axis does not stall, with the read overlapped.
// An end-of-name word is followed by the zero byte.
// The store needs no clearing after reset; only entries of the current label are read.
// Stalls on m_axis hold the sequencer; new input waits until the run is handed off.
module dns_label_encoder (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid_i,
  output logic       s_axis_tready_o,
  input  logic [7:0] s_axis_tdata_i,   // [7:0] name_char
  input  logic       s_axis_tuser_i,   // [0] func
  output logic       m_axis_tvalid_o,
  input  logic       m_axis_tready_i,
  output logic [7:0] m_axis_tdata_o,   // [7:0] out_byte
  output logic       m_axis_tuser_o,   // [0] label_truncated
  output logic       m_axis_tlast_o
);

  dle_pkg::out_word_t             out_word;
  dle_pkg::ram_req_t              ram_req;
  logic [dle_pkg::ByteW-1:0]      ram_rdata;
  logic                           out_free;
  logic                           out_valid_q;
  logic [dle_pkg::ByteW-1:0]      out_byte_q;
  logic                           out_last_q;
  logic                           out_trunc_q;

  assign out_free = !out_valid_q || m_axis_tready_i;

  dle_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .in_func_i   (s_axis_tuser_i),
    .in_char_i   (s_axis_tdata_i),
    .out_free_i  (out_free),
    .out_word_o  (out_word),
    .ram_req_o   (ram_req),
    .ram_rdata_i (ram_rdata)
  );

  dle_ram #(
    .Depth (dle_pkg::MaxLabel),
    .Width (dle_pkg::ByteW),
    .AddrW (dle_pkg::AddrW)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_req.we),
    .waddr_i (ram_req.waddr),
    .wdata_i (ram_req.wdata),
    .re_i    (ram_req.re),
    .raddr_i (ram_req.raddr),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_word.vld) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_word.vld) begin
      out_byte_q  <= out_word.out_byte;
      out_last_q  <= out_word.run_last;
      out_trunc_q <= out_word.label_truncated;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_byte_q;
  assign m_axis_tlast_o  = out_last_q;
  assign m_axis_tuser_o  = out_trunc_q;

endmodule

// ===== tb/tb_dns_label_encoder.sv =====
// Self-checking testbench of the DNS label encoder: directed table, then random names.
module tb_dns_label_encoder;

  typedef struct packed {
    logic [7:0] value;
    logic       last;
    logic       trunc;
  } wire_byte_t;

  typedef struct {
    logic       func;
    logic [7:0] ch;
    int         reps;
    bit         typed;
    wire_byte_t want;
  } dir_row_t;

  localparam wire_byte_t ZeroEnd = '{value: 8'h00, last: 1'b1, trunc: 1'b0};
  localparam wire_byte_t NoWant  = '{value: 8'h00, last: 1'b0, trunc: 1'b0};

  logic       clk_i;
  logic       rst_ni;
  logic       s_valid;
  logic [7:0] s_data;
  logic       s_user;
  logic       m_ready;
  logic       s_axis_tready_o;
  logic       m_axis_tvalid_o;
  logic [7:0] m_axis_tdata_o;
  logic       m_axis_tuser_o;
  logic       m_axis_tlast_o;

  dns_label_encoder u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_data),    // [7:0] name_char
    .s_axis_tuser_i  (s_user),    // [0] func
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_axis_tdata_o),  // [7:0] out_byte
    .m_axis_tuser_o  (m_axis_tuser_o),  // [0] label_truncated
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  // Typed results are given only for single-word runs: ends of name and empty labels.
  dir_row_t dir_tab [21] = '{
    '{dle_pkg::FuncEnd,  8'h00,            1, 1'b1, ZeroEnd},
    '{dle_pkg::FuncChar, dle_pkg::DotChar, 1, 1'b1, ZeroEnd},
    '{dle_pkg::FuncChar, 8'h00,            1, 1'b0, NoWant},
    '{dle_pkg::FuncChar, 8'hFF,            1, 1'b0, NoWant},
    '{dle_pkg::FuncChar, 8'h2D,            1, 1'b0, NoWant},
    '{dle_pkg::FuncChar, dle_pkg::DotChar, 1, 1'b0, NoWant},
    '{dle_pkg::FuncChar, dle_pkg::DotChar, 1, 1'b1, ZeroEnd},
    '{dle_pkg::FuncChar, 8'h61,            1, 1'b0, NoWant},
    '{dle_pkg::FuncChar, 8'h62,            1, 1'b0, NoWant},
    '{dle_pkg::FuncEnd,  8'hFF,            1, 1'b1, ZeroEnd},
    '{dle_pkg::FuncChar, dle_pkg::DotChar, 1, 1'b1, ZeroEnd},
    '{dle_pkg::FuncChar, 8'h41,           63, 1'b0, NoWant},
    '{dle_pkg::FuncChar, dle_pkg::DotChar, 1, 1'b0, NoWant},
    '{dle_pkg::FuncChar, 8'h7A,           66, 1'b0, NoWant},
    '{dle_pkg::FuncChar, dle_pkg::DotChar, 1, 1'b0, NoWant},
    '{dle_pkg::FuncChar, 8'h30,           70, 1'b0, NoWant},
    '{dle_pkg::FuncEnd,  dle_pkg::DotChar, 1, 1'b1, ZeroEnd},
    '{dle_pkg::FuncChar, dle_pkg::DotChar, 1, 1'b1, ZeroEnd},
    '{dle_pkg::FuncChar, 8'h80,            1, 1'b0, NoWant},
    '{dle_pkg::FuncChar, 8'h7F,            1, 1'b0, NoWant},
    '{dle_pkg::FuncChar, dle_pkg::DotChar, 1, 1'b0, NoWant}
  };

  // Encoder state as seen from outside.
  logic [7:0]               lbl_chars [dle_pkg::MaxLabel];
  logic [dle_pkg::CntW-1:0] lbl_len;
  logic                     lbl_over;

  wire_byte_t run_buf [$];
  wire_byte_t wire_bytes_q [$];

  int  err_cnt;
  int  words_sent;
  int  names_sent;
  int  bytes_seen;
  int  trunc_seen;
  int  longest_run;
  bit  tx_burst;
  bit  rx_burst;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #20000000;
    $display("tb_dns_label_encoder: errors");
    $finish;
  end

  // Leaves the run caused by one word in run_buf and advances the label state.
  task automatic encode_word(input logic f, input logic [7:0] c);
    wire_byte_t wb;
    run_buf.delete();
    if (f == dle_pkg::FuncEnd) begin
      lbl_len  = '0;
      lbl_over = 1'b0;
      run_buf.push_back(ZeroEnd);
    end else if (c != dle_pkg::DotChar) begin
      if (lbl_len < dle_pkg::MaxLabel) begin
        lbl_chars[lbl_len] = c;
        lbl_len++;
      end else begin
        lbl_over = 1'b1;
      end
    end else begin
      wb = '{value: 8'(lbl_len), last: (lbl_len == 0), trunc: lbl_over};
      run_buf.push_back(wb);
      for (int i = 0; i < lbl_len; i++) begin
        wb = '{value: lbl_chars[i], last: (i + 1 == lbl_len), trunc: lbl_over};
        run_buf.push_back(wb);
      end
      lbl_len  = '0;
      lbl_over = 1'b0;
    end
  endtask

  task automatic send_word(input logic f, input logic [7:0] c, input bit typed,
                           input wire_byte_t want);
    int gap;
    gap = tx_burst ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      s_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_valid <= 1'b1;
    s_user  <= f;
    s_data  <= c;
    do @(posedge clk_i); while (!s_axis_tready_o);
    words_sent++;
    encode_word(f, c);
    if (run_buf.size() > longest_run) longest_run = run_buf.size();
    if (typed) begin
      if (run_buf.size() != 1 || run_buf[0] != want) begin
        err_cnt++;
        $display("%0t: table entry expected %h, predictor gives %0d words starting %h",
                 $time, want, run_buf.size(), run_buf[0]);
      end
      wire_bytes_q.push_back(want);
    end else begin
      foreach (run_buf[i]) wire_bytes_q.push_back(run_buf[i]);
    end
  endtask

  // Holds the input back until every pending output word has been taken.
  task automatic drain_output();
    s_valid <= 1'b0;
    do @(posedge clk_i); while (wire_bytes_q.size() != 0);
  endtask

  function automatic logic [7:0] label_char();
    logic [7:0] c;
    c = 8'($urandom_range(0, 255));
    if (c == dle_pkg::DotChar) c = 8'h2F;
    return c;
  endfunction

  // Output side: random stalls per word, with stretches of full throughput.
  initial begin : rx_side
    int stall;
    rx_burst = 1'b0;
    forever begin
      if ($urandom_range(0, 29) == 0) rx_burst = !rx_burst;
      stall = rx_burst ? 0 : $urandom_range(0, 9);
      if (stall > 0) begin
        m_ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_ready <= 1'b1;
      do @(posedge clk_i); while (!(rst_ni && m_axis_tvalid_o));
    end
  end

  always @(posedge clk_i) begin : out_check
    wire_byte_t want;
    if (rst_ni && m_axis_tvalid_o && m_ready) begin
      bytes_seen++;
      if (m_axis_tuser_o) trunc_seen++;
      if (wire_bytes_q.size() == 0) begin
        err_cnt++;
        $display("%0t: output word %h (last %b, truncated %b) with nothing expected",
                 $time, m_axis_tdata_o, m_axis_tlast_o, m_axis_tuser_o);
      end else begin
        want = wire_bytes_q.pop_front();
        if (m_axis_tdata_o !== want.value) begin
          err_cnt++;
          $display("%0t: out_byte expected %h, got %h", $time, want.value, m_axis_tdata_o);
        end
        if (m_axis_tlast_o !== want.last) begin
          err_cnt++;
          $display("%0t: run_last expected %b, got %b", $time, want.last, m_axis_tlast_o);
        end
        if (m_axis_tuser_o !== want.trunc) begin
          err_cnt++;
          $display("%0t: label_truncated expected %b, got %b",
                   $time, want.trunc, m_axis_tuser_o);
        end
      end
    end
  end

  initial begin : stim
    int n_lbl;
    int len;
    int wait_cnt;
    s_valid     <= 1'b0;
    s_data      <= 8'h00;
    s_user      <= dle_pkg::FuncChar;
    rst_ni      <= 1'b0;
    err_cnt     = 0;
    words_sent  = 0;
    names_sent  = 0;
    bytes_seen  = 0;
    trunc_seen  = 0;
    longest_run = 0;
    tx_burst    = 1'b0;
    lbl_len     = '0;
    lbl_over    = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_tab[r]) begin
      for (int k = 0; k < dir_tab[r].reps; k++) begin
        send_word(dir_tab[r].func, dir_tab[r].ch, dir_tab[r].typed, dir_tab[r].want);
      end
    end
    drain_output();

    while (words_sent < 270) begin
      tx_burst = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 7) == 0) begin
        // Noise: any byte, dots included, and stray ends of name.
        repeat ($urandom_range(1, 12)) begin
          send_word(($urandom_range(0, 7) == 0) ? dle_pkg::FuncEnd : dle_pkg::FuncChar,
                    8'($urandom_range(0, 255)), 1'b0, NoWant);
        end
      end else begin
        n_lbl = $urandom_range(1, 4);
        for (int l = 0; l < n_lbl; l++) begin
          len = ($urandom_range(0, 19) == 0) ? $urandom_range(61, 70) : $urandom_range(0, 9);
          repeat (len) send_word(dle_pkg::FuncChar, label_char(), 1'b0, NoWant);
          send_word(dle_pkg::FuncChar, dle_pkg::DotChar, 1'b0, NoWant);
        end
        // Sometimes leave an unterminated label for the end of name to drop.
        if ($urandom_range(0, 3) == 0) begin
          repeat ($urandom_range(1, 6)) begin
            send_word(dle_pkg::FuncChar, label_char(), 1'b0, NoWant);
          end
        end
        send_word(dle_pkg::FuncEnd, 8'($urandom_range(0, 255)), 1'b0, NoWant);
        names_sent++;
      end
      if ($urandom_range(0, 5) == 0) drain_output();
    end

    s_valid <= 1'b0;
    while (wire_bytes_q.size() != 0) @(posedge clk_i);
    wait_cnt = 0;
    while (wait_cnt < 10) begin
      @(posedge clk_i);
      wait_cnt++;
    end

    $display("Sent %0d input words (%0d random names, %0d directed rows); checked %0d outputs",
             words_sent, names_sent, $size(dir_tab), bytes_seen);
    $display("Output words with the truncation flag: %0d; longest run: %0d words",
             trunc_seen, longest_run);
    if (err_cnt == 0) begin
      $display("tb_dns_label_encoder: clean");
    end else begin
      $display("tb_dns_label_encoder: errors");
    end
    $finish;
  end

endmodule
